// ----- rtl/bitmap_pixel_unpacker_assert.svh -----
// assertion macros for the bitmap pixel unpacker
`ifndef BITMAP_PIXEL_UNPACKER_ASSERT_SVH
`define BITMAP_PIXEL_UNPACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BPU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold in the first cycle after reset is released
`define BPU_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) ($past(rst) && !rst) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bpu_pkg.sv -----
// shared types and constants of the bitmap pixel unpacker
package bpu_pkg;

  // source format codes
  localparam logic [15:0] FMT_GRAY1  = 16'h0001;
  localparam logic [15:0] FMT_GRAY8  = 16'h0002;
  localparam logic [15:0] FMT_RGB24  = 16'h0003;
  localparam logic [15:0] FMT_CMAP8  = 16'h0004;
  localparam logic [15:0] FMT_RGB32  = 16'h0008;
  localparam logic [15:0] FMT_RGBA32 = 16'h2008;

  // result status codes
  localparam logic [1:0] ST_PIXEL = 2'd0;
  localparam logic [1:0] ST_DIM   = 2'd1;
  localparam logic [1:0] ST_FMT   = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  // item opcodes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // register indexes
  localparam logic [2:0] REG_FORMAT  = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_STRIDE  = 3'd3;
  localparam logic [2:0] REG_PALETTE = 3'd4;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0] color_format;
    logic [13:0] image_width;
    logic [13:0] image_height;
    logic [15:0] row_stride;
    logic [8:0]  palette_entries;
  } cfg_t;

  // one decoded byte: a single result, or a run of up to eight gray1 pixels
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [12:0] x_base;
    logic [12:0] y;
    logic        gray1;
    logic [7:0]  bits;
    logic [3:0]  count;
    logic        img_end;
  } job_t;

  // queue handshake between the parts
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/bpu_if.sv -----
// item channel interfaces: raw bytes in, decoded pixels out
interface bpu_byte_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic [7:0] entry_index;
  logic [7:0] entry_red;
  logic [7:0] entry_green;
  logic [7:0] entry_blue;
  logic [7:0] entry_alpha;

  modport source (
    output valid, opcode, data_byte, entry_index, entry_red, entry_green,
           entry_blue, entry_alpha,
    input  ready
  );
  modport sink (
    input  valid, opcode, data_byte, entry_index, entry_red, entry_green,
           entry_blue, entry_alpha,
    output ready
  );
endinterface

interface bpu_pixel_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_alpha;
  logic [12:0] pixel_x;
  logic [12:0] pixel_y;
  logic        last_of_run;
  logic        last_of_image;

  modport source (
    output valid, status, out_blue, out_green, out_red, out_alpha, pixel_x,
           pixel_y, last_of_run, last_of_image,
    input  ready
  );
  modport sink (
    input  valid, status, out_blue, out_green, out_red, out_alpha, pixel_x,
           pixel_y, last_of_run, last_of_image,
    output ready
  );
endinterface

// ----- rtl/bpu_queue.sv -----
// short job queue between the front and back parts
module bpu_queue import bpu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_ctl_t  ctl,
  input  job_t    wr_job,
  output job_t    head,
  output q_stat_t stat
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;

  assign stat.full  = (level == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (level == '0);
  assign head       = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (ctl.push) wr_ptr <= wr_ptr + 1'b1;
      if (ctl.pop)  rd_ptr <= rd_ptr + 1'b1;
      if (ctl.push && !ctl.pop)      level <= level + 1'b1;
      else if (!ctl.push && ctl.pop) level <= level - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (ctl.push) entries[wr_ptr] <= wr_job;
  end

endmodule

// ----- rtl/bpu_front.sv -----
// front part: takes bytes and palette entries, tracks row position, classifies and builds jobs
module bpu_front import bpu_pkg::*; #(
  parameter int MAX_DIM       = 8192,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  bpu_byte_if.sink    byte_ch,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_taken
);

  localparam int          AW     = $clog2(PALETTE_DEPTH);
  localparam logic [16:0] MAXD   = 17'(MAX_DIM);
  localparam logic [8:0]  PDEPTH = 9'(PALETTE_DEPTH);

  // position state
  logic [15:0] byte_in_row;
  logic [12:0] row_index;
  logic [23:0] partial_pixel;

  // stage register and palette read data
  logic        stg_valid;
  job_t        stg_job;
  logic        stg_pal;
  logic        stg_pal_ok;
  logic [31:0] pal_rd;
  logic [31:0] palette_store [PALETTE_DEPTH];

  logic        accept;
  logic        take_byte;
  logic        take_entry;
  logic        dim_bad;
  logic        fmt_known;
  logic        is_gray1;
  logic        is_gray8;
  logic        is_cmap;
  logic        is_rgb32;
  logic        is_rgba;
  logic        is4;
  logic [16:0] minrow;
  logic [1:0]  st;
  logic        active;
  logic        row_end;
  logic        last_row;
  logic [13:0] row_inc;
  logic [31:0] prod3;
  logic [14:0] q3;
  logic [15:0] rem3;
  logic [1:0]  phase;
  logic        last_phase;
  logic [12:0] x_sel;
  logic [18:0] pos8;
  logic [18:0] rem1;
  logic [3:0]  n1;
  logic [23:0] part_upd;
  logic        pal_hit;
  logic        have_res;
  job_t        job_n;

  assign accept     = byte_ch.valid && byte_ch.ready;
  assign take_byte  = accept && (byte_ch.opcode == OP_DATA);
  assign take_entry = accept && (byte_ch.opcode == OP_PALETTE);
  assign byte_ch.ready = !stg_valid || job_taken;
  assign job_valid  = stg_valid;

  // format and dimension checks
  always_comb begin
    is_gray1 = (cfg.color_format == FMT_GRAY1);
    is_gray8 = (cfg.color_format == FMT_GRAY8);
    is_cmap  = (cfg.color_format == FMT_CMAP8);
    is_rgb32 = (cfg.color_format == FMT_RGB32);
    is_rgba  = (cfg.color_format == FMT_RGBA32);
    is4      = is_rgb32 || is_rgba;
    dim_bad  = (cfg.image_width == '0) || (17'(cfg.image_width) > MAXD) ||
               (cfg.image_height == '0) || (17'(cfg.image_height) > MAXD) ||
               (cfg.row_stride == '0);
    fmt_known = 1'b1;
    case (cfg.color_format)
      FMT_RGB32, FMT_RGBA32: minrow = {1'b0, cfg.image_width, 2'b00};
      FMT_RGB24: minrow = 17'(cfg.image_width) + {2'b00, cfg.image_width, 1'b0};
      FMT_GRAY8, FMT_CMAP8: minrow = 17'(cfg.image_width);
      FMT_GRAY1: minrow = (17'(cfg.image_width) + 17'd7) >> 3;
      default: begin
        minrow    = '0;
        fmt_known = 1'b0;
      end
    endcase
    if (dim_bad)                            st = ST_DIM;
    else if (!fmt_known)                    st = ST_FMT;
    else if (17'(cfg.row_stride) < minrow) st = ST_SHORT;
    else                                    st = ST_PIXEL;
    active = (st == ST_PIXEL) && (17'(byte_in_row) < minrow);
  end

  // row bookkeeping
  always_comb begin
    row_end  = (17'(byte_in_row) + 17'd1) >= 17'(cfg.row_stride);
    row_inc  = 14'(row_index) + 14'd1;
    last_row = (row_inc == cfg.image_height);
  end

  // byte phase within a pixel; divide by three through a reciprocal
  always_comb begin
    prod3 = 32'(byte_in_row) * 32'd43691;
    q3    = prod3[31:17];
    rem3  = byte_in_row - ({q3, 1'b0} + 16'(q3));
    phase = is4 ? byte_in_row[1:0] : rem3[1:0];
    last_phase = is4 ? (phase == 2'd3) : (phase == 2'd2);
  end

  // gray1 run length: pixels of this byte that still fall inside the row
  always_comb begin
    pos8 = {byte_in_row, 3'b000};
    rem1 = 19'(cfg.image_width) - pos8;
    n1   = (rem1 >= 19'd8) ? 4'd8 : rem1[3:0];
  end

  // partial pixel lanes for rgb formats
  always_comb begin
    part_upd = partial_pixel;
    case (phase)
      2'd0:    part_upd[7:0]   = byte_ch.data_byte;
      2'd1:    part_upd[15:8]  = byte_ch.data_byte;
      2'd2:    part_upd[23:16] = byte_ch.data_byte;
      default: part_upd = partial_pixel;
    endcase
  end

  // job for this byte
  always_comb begin
    pal_hit  = ({1'b0, byte_ch.data_byte} < cfg.palette_entries) &&
               ({1'b0, byte_ch.data_byte} < PDEPTH);
    if (is_gray1)                x_sel = pos8[12:0];
    else if (is_gray8 || is_cmap) x_sel = byte_in_row[12:0];
    else if (is4)                x_sel = byte_in_row[14:2];
    else                         x_sel = q3[12:0];
    have_res = (st != ST_PIXEL) ||
               (active && (is_gray1 || is_gray8 || is_cmap || last_phase));
    job_n        = '0;
    job_n.status = st;
    job_n.count  = 4'd1;
    if (st == ST_PIXEL) begin
      job_n.y       = row_index;
      job_n.x_base  = x_sel;
      job_n.img_end = last_row && ((17'(x_sel) + 17'd1) == 17'(cfg.image_width));
      if (is_gray1) begin
        job_n.gray1   = 1'b1;
        job_n.bits    = byte_ch.data_byte;
        job_n.count   = n1;
        job_n.img_end = last_row && (rem1 <= 19'd8);
        job_n.alpha   = 8'hFF;
      end else if (is_gray8) begin
        job_n.blue  = byte_ch.data_byte;
        job_n.green = byte_ch.data_byte;
        job_n.red   = byte_ch.data_byte;
        job_n.alpha = 8'hFF;
      end else if (!is_cmap) begin
        job_n.blue  = part_upd[7:0];
        job_n.green = part_upd[15:8];
        job_n.red   = part_upd[23:16];
        job_n.alpha = is_rgba ? byte_ch.data_byte : 8'hFF;
      end
    end
  end

  // control and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid     <= 1'b0;
      byte_in_row   <= '0;
      row_index     <= '0;
      partial_pixel <= '0;
    end else begin
      if (accept)         stg_valid <= take_byte && have_res;
      else if (job_taken) stg_valid <= 1'b0;
      if (take_byte && (st == ST_PIXEL)) begin
        if (row_end) begin
          byte_in_row   <= '0;
          partial_pixel <= '0;
          row_index     <= (row_inc >= cfg.image_height) ? '0 : row_inc[12:0];
        end else begin
          byte_in_row <= byte_in_row + 16'd1;
          if (active && !is_gray1 && !is_gray8 && !is_cmap) partial_pixel <= part_upd;
        end
      end
    end
  end

  // stage payload and palette memory
  always_ff @(posedge clk) begin
    if (take_byte) begin
      stg_job    <= job_n;
      stg_pal    <= is_cmap && (st == ST_PIXEL);
      stg_pal_ok <= pal_hit;
      pal_rd     <= palette_store[byte_ch.data_byte[AW-1:0]];
    end
    if (take_entry && ({1'b0, byte_ch.entry_index} < PDEPTH)) begin
      palette_store[byte_ch.entry_index[AW-1:0]] <=
        {byte_ch.entry_alpha, byte_ch.entry_red, byte_ch.entry_green, byte_ch.entry_blue};
    end
  end

  // palette colour replaces the stage colour on the way to the queue
  always_comb begin
    job = stg_job;
    if (stg_pal) begin
      {job.alpha, job.red, job.green, job.blue} = stg_pal_ok ? pal_rd : 32'd0;
    end
  end

endmodule

// ----- rtl/bpu_back.sv -----
// back part: expands jobs into result items behind an output register
module bpu_back import bpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  logic        head_valid,
  output logic        head_done,
  bpu_pixel_if.source pixel_ch
);

  logic [2:0]  cnt;
  logic        load;
  logic        final_px;
  logic        bit_on;
  logic        out_valid;

  assign load      = !out_valid || pixel_ch.ready;
  assign final_px  = (4'(cnt) + 4'd1) >= head.count;
  assign bit_on    = head.bits[cnt];
  assign head_done = load && head_valid && final_px;
  assign pixel_ch.valid = out_valid;

  // run counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) cnt <= final_px ? 3'd0 : cnt + 3'd1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      pixel_ch.status        <= head.status;
      pixel_ch.pixel_x       <= head.x_base + 13'(cnt);
      pixel_ch.pixel_y       <= head.y;
      pixel_ch.out_alpha     <= head.alpha;
      pixel_ch.last_of_run   <= final_px;
      pixel_ch.last_of_image <= final_px && head.img_end;
      if (head.gray1) begin
        pixel_ch.out_blue  <= bit_on ? 8'hFF : 8'h00;
        pixel_ch.out_green <= bit_on ? 8'hFF : 8'h00;
        pixel_ch.out_red   <= bit_on ? 8'hFF : 8'h00;
      end else begin
        pixel_ch.out_blue  <= head.blue;
        pixel_ch.out_green <= head.green;
        pixel_ch.out_red   <= head.red;
      end
    end
  end

endmodule

// ----- rtl/bitmap_pixel_unpacker.sv -----
// bitmap pixel unpacker top level: register port, front, queue and back
// takes one byte or palette entry per cycle unless the full queue holds up the stage;
// a byte that yields results goes through the stage register, queue and output register;
// one result per cycle leaves the output register while the receiver is ready; a gray1
// byte holds the back part for up to eight results while the four-entry queue absorbs the difference
// reset clears position state, queue and registers; the palette is not cleared
module bitmap_pixel_unpacker import bpu_pkg::*; #(
  parameter int MAX_DIM       = 8192,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bpu_byte_if.sink    byte_ch,
  bpu_pixel_if.source pixel_ch
);

  cfg_t    cfg;
  job_t    fe_job;
  job_t    q_head;
  logic    fe_valid;
  logic    be_done;
  q_ctl_t  q_ctl;
  q_stat_t q_stat;
  logic    reg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_FORMAT:  cfg.color_format    <= pwdata[15:0];
        REG_WIDTH:   cfg.image_width     <= pwdata[13:0];
        REG_HEIGHT:  cfg.image_height    <= pwdata[13:0];
        REG_STRIDE:  cfg.row_stride      <= pwdata[15:0];
        REG_PALETTE: cfg.palette_entries <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_FORMAT:  prdata = 32'(cfg.color_format);
      REG_WIDTH:   prdata = 32'(cfg.image_width);
      REG_HEIGHT:  prdata = 32'(cfg.image_height);
      REG_STRIDE:  prdata = 32'(cfg.row_stride);
      REG_PALETTE: prdata = 32'(cfg.palette_entries);
      default:     prdata = 32'd0;
    endcase
  end

  // queue handshake
  assign q_ctl.push = fe_valid && !q_stat.full;
  assign q_ctl.pop  = be_done;

  bpu_front #(
    .MAX_DIM       (MAX_DIM),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .byte_ch   (byte_ch),
    .job       (fe_job),
    .job_valid (fe_valid),
    .job_taken (q_ctl.push)
  );

  bpu_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctl    (q_ctl),
    .wr_job (fe_job),
    .head   (q_head),
    .stat   (q_stat)
  );

  bpu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .head_done  (be_done),
    .pixel_ch   (pixel_ch)
  );

  `include "bitmap_pixel_unpacker_assert.svh"

  `BPU_ASSERT_IMPLY(a_err_lone, pixel_ch.valid && (pixel_ch.status != ST_PIXEL), pixel_ch.last_of_run && !pixel_ch.last_of_image && (pixel_ch.pixel_x == '0) && (pixel_ch.pixel_y == '0), "error result is not a lone zeroed item")
  `BPU_ASSERT_IMPLY(a_img_end_run, pixel_ch.valid && pixel_ch.last_of_image, pixel_ch.last_of_run && (pixel_ch.status == ST_PIXEL), "image end not on the last pixel of a run")
  `BPU_ASSERT_IMPLY(a_x_in_row, pixel_ch.valid && (pixel_ch.status == ST_PIXEL), 14'(pixel_ch.pixel_x) < cfg.image_width, "pixel column beyond the row")
  `BPU_ASSERT_AFTER_RESET(a_ready_after_reset, byte_ch.ready && !pixel_ch.valid, "block not idle after reset")

endmodule
